// ===== sv/rcpc_pkg.sv =====
// Package for the random-cycle pointer chase core.
// Holds the sequencer states, request and register codes, and the xorshift step.
// No dependencies.
package rcpc_pkg;

	localparam logic [63:0] SEED_RESET = 64'h9E3779B97F4A7C15;
	localparam int unsigned XS_A = 13;
	localparam int unsigned XS_B = 7;
	localparam int unsigned XS_C = 17;
	localparam int unsigned DIV_STEPS = 64;

	typedef enum logic [1:0] {
		REQ_BUILD   = 2'd0,
		REQ_ADVANCE = 2'd1,
		REQ_READ    = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		CFG_LOG_NODES  = 2'd0,
		CFG_NUM_CHAINS = 2'd1,
		CFG_SEED       = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RESP,
		S_STEP,
		S_STEP_W,
		S_INIT,
		S_SH_RNG,
		S_SH_DIV,
		S_SH_RDK,
		S_SH_RDJ,
		S_SH_WRK,
		S_SH_WRJ,
		S_LK_RD,
		S_LK_WR,
		S_LK_END,
		S_CU_RD,
		S_CU_WR
	} state_t;

	function automatic logic [63:0] xorshift64(input logic [63:0] x);
		logic [63:0] a;
		logic [63:0] b;
		a = x ^ (x << XS_A);
		b = a ^ (a >> XS_B);
		return b ^ (b << XS_C);
	endfunction

endpackage

// ===== sv/rcpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rcpc_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/rcpc_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Used for the shuffle partner (x mod k+1) and the cursor spacing. Uses rcpc_pkg.
module rcpc_divider
	import rcpc_pkg::*;
#(
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [63:0]   quotient,
	output logic [DW-1:0] remainder
);
	logic [63:0]   q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [6:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   d_ext;
	logic          fits;

	assign trial = {r_q, q_q[63]};
	assign d_ext = {1'b0, d_q};
	assign fits  = trial >= d_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			q_q <= {q_q[62:0], fits};
			r_q <= fits ? DW'(trial - d_ext) : trial[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;
endmodule

// ===== sv/random_cycle_pointer_chase_core.sv =====
// Channel   | ports                              | handshake
// request   | req_type, index                    | start && !busy
// result    | node, error                        | done, one cycle, no stall
// config    | cfg_addr, cfg_wdata                | cfg_we
// Advance and read requests: the successor RAM read is issued in the accept
// cycle and the result shows in the next, when a new request may already be
// taken. A build is dominated by the shuffle step, which waits on a full
// divider run for each shuffled node. Reset clears only control state; node
// RAMs and cursors hold nothing valid until the first build.
// Uses rcpc_pkg, rcpc_ram, rcpc_divider.
module random_cycle_pointer_chase_core
	import rcpc_pkg::*;
#(
	parameter int MAX_LOG_NODES = 16,
	parameter int MAX_CHAINS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] index,
	output logic        done,
	output logic [15:0] node,
	output logic        error,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);
	localparam int NW    = MAX_LOG_NODES;
	localparam int DEPTH = 1 << NW;
	localparam int DW    = NW + 1;
	localparam int CW    = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
	localparam int CHW   = $clog2(MAX_CHAINS + 1);
	localparam int IW    = (NW > 16) ? NW : 16;

	state_t state_q, state_d;

	logic [4:0]     log_nodes_q;
	logic [4:0]     num_chains_q;
	logic [63:0]    seed_q;
	logic           built_q;
	logic [NW-1:0]  mask_q;
	logic [CHW-1:0] ch_q;
	logic [63:0]    rng_q;
	logic [NW-1:0]  k_q;
	logic [NW-1:0]  j_q;
	logic [NW-1:0]  ok_q;
	logic [NW-1:0]  first_q;
	logic [NW-1:0]  prev_q;
	logic [DW-1:0]  step_q;
	logic [DW-1:0]  pos_q;
	logic [CW-1:0]  c_q;
	logic           err_q;
	logic           from_mem_q;
	logic           adv_q;
	logic [CW-1:0]  sel_q;
	logic [NW-1:0]  cursors_q [MAX_CHAINS];

	logic           accept;
	logic [4:0]     lg_sat;
	logic [6:0]     nc_ext;
	logic [6:0]     ch_sat;
	logic [CW-1:0]  idx_sel;
	logic [NW-1:0]  cur_rd;
	logic [IW-1:0]  idx_ext;
	logic [IW-1:0]  succ_ext;
	logic           adv_ok;
	logic [63:0]    rng_next;

	logic           ord_we, succ_we;
	logic [NW-1:0]  ord_waddr, ord_wdata, ord_raddr, ord_rdata;
	logic [NW-1:0]  succ_waddr, succ_wdata, succ_raddr, succ_rdata;

	logic           div_start, div_done;
	logic [63:0]    div_dividend, div_quot;
	logic [DW-1:0]  div_divisor, div_rem;

	rcpc_ram #(.W(NW), .DEPTH(DEPTH)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	rcpc_ram #(.W(NW), .DEPTH(DEPTH)) u_succ (
		.clk(clk), .we(succ_we), .waddr(succ_waddr), .wdata(succ_wdata),
		.raddr(succ_raddr), .rdata(succ_rdata)
	);

	rcpc_divider #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quot),
		.remainder(div_rem)
	);

	assign busy     = !(state_q == S_IDLE || state_q == S_RESP);
	assign accept   = start && !busy;
	assign done     = state_q == S_RESP;
	assign succ_ext = IW'(succ_rdata);
	assign node     = (done && from_mem_q) ? succ_ext[15:0] : 16'd0;
	assign error    = done && err_q;
	assign idx_ext  = IW'(index);
	assign idx_sel  = CW'(index);
	assign adv_ok   = index < 16'(ch_q);
	assign rng_next = xorshift64(rng_q);
	assign nc_ext   = 7'(num_chains_q);

	always_comb begin
		if (log_nodes_q < 5'd4) begin
			lg_sat = 5'd4;
		end else if (log_nodes_q > 5'(NW)) begin
			lg_sat = 5'(NW);
		end else begin
			lg_sat = log_nodes_q;
		end
		if (nc_ext == 7'd0) begin
			ch_sat = 7'd1;
		end else if (nc_ext > 7'(MAX_CHAINS)) begin
			ch_sat = 7'(MAX_CHAINS);
		end else begin
			ch_sat = nc_ext;
		end
		if (state_q == S_RESP && adv_q && sel_q == idx_sel) begin
			cur_rd = succ_rdata;
		end else begin
			cur_rd = cursors_q[idx_sel];
		end
	end

	always_comb begin
		state_d      = state_q;
		ord_we       = 1'b0;
		ord_waddr    = k_q;
		ord_wdata    = k_q;
		ord_raddr    = k_q;
		succ_we      = 1'b0;
		succ_waddr   = prev_q;
		succ_wdata   = ord_rdata;
		succ_raddr   = cur_rd;
		div_start    = 1'b0;
		div_dividend = rng_next;
		div_divisor  = DW'(k_q) + DW'(1);
		unique case (state_q)
			S_IDLE, S_RESP: begin
				if (state_q == S_RESP) begin
					state_d = S_IDLE;
				end
				if (accept) begin
					if (req_type == REQ_READ) begin
						succ_raddr = idx_ext[NW-1:0] & mask_q;
					end
					if (req_type == REQ_BUILD) begin
						state_d = S_STEP;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_STEP: begin
				div_start    = 1'b1;
				div_dividend = 64'(mask_q) + 64'd1;
				div_divisor  = DW'(ch_q);
				state_d      = S_STEP_W;
			end
			S_STEP_W: begin
				if (div_done) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				ord_we = 1'b1;
				if (k_q == mask_q) begin
					state_d = S_SH_RNG;
				end
			end
			S_SH_RNG: begin
				div_start = 1'b1;
				state_d   = S_SH_DIV;
			end
			S_SH_DIV: begin
				if (div_done) begin
					state_d = S_SH_RDK;
				end
			end
			S_SH_RDK: begin
				state_d = S_SH_RDJ;
			end
			S_SH_RDJ: begin
				ord_raddr = j_q;
				state_d   = S_SH_WRK;
			end
			S_SH_WRK: begin
				ord_we    = 1'b1;
				ord_wdata = ord_rdata;
				state_d   = S_SH_WRJ;
			end
			S_SH_WRJ: begin
				ord_we    = 1'b1;
				ord_waddr = j_q;
				ord_wdata = ok_q;
				state_d   = (k_q == NW'(1)) ? S_LK_RD : S_SH_RNG;
			end
			S_LK_RD: begin
				state_d = S_LK_WR;
			end
			S_LK_WR: begin
				succ_we = k_q != '0;
				state_d = (k_q == mask_q) ? S_LK_END : S_LK_RD;
			end
			S_LK_END: begin
				succ_we    = 1'b1;
				succ_wdata = first_q;
				state_d    = S_CU_RD;
			end
			S_CU_RD: begin
				ord_raddr = pos_q[NW-1:0];
				state_d   = S_CU_WR;
			end
			S_CU_WR: begin
				state_d = (CHW'(c_q) + CHW'(1) == ch_q) ? S_RESP : S_CU_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			log_nodes_q  <= 5'd16;
			num_chains_q <= 5'd1;
			seed_q       <= SEED_RESET;
			built_q      <= 1'b0;
			err_q        <= 1'b0;
			from_mem_q   <= 1'b0;
			adv_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_LOG_NODES:  log_nodes_q  <= cfg_wdata[4:0];
					CFG_NUM_CHAINS: num_chains_q <= cfg_wdata[4:0];
					CFG_SEED:       seed_q       <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				err_q      <= 1'b0;
				from_mem_q <= 1'b0;
				adv_q      <= 1'b0;
				if (req_type == REQ_ADVANCE || req_type == REQ_READ) begin
					if (!built_q) begin
						err_q <= 1'b1;
					end else if (req_type == REQ_READ) begin
						from_mem_q <= 1'b1;
					end else if (adv_ok) begin
						from_mem_q <= 1'b1;
						adv_q      <= 1'b1;
					end
				end
			end else if (state_q == S_RESP) begin
				adv_q <= 1'b0;
			end
			if (state_q == S_CU_WR && state_d == S_RESP) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && adv_q) begin
			cursors_q[sel_q] <= succ_rdata;
		end
		if (accept) begin
			sel_q <= idx_sel;
			if (req_type == REQ_BUILD) begin
				mask_q <= ~({NW{1'b1}} << lg_sat);
				ch_q   <= CHW'(ch_sat);
				rng_q  <= seed_q;
			end
		end
		unique case (state_q)
			S_STEP_W: begin
				step_q <= div_quot[DW-1:0];
				k_q    <= '0;
			end
			S_INIT: begin
				k_q <= (k_q == mask_q) ? mask_q : k_q + NW'(1);
			end
			S_SH_RNG: begin
				rng_q <= rng_next;
			end
			S_SH_DIV: begin
				j_q <= div_rem[NW-1:0];
			end
			S_SH_RDJ: begin
				ok_q <= ord_rdata;
			end
			S_SH_WRJ: begin
				k_q <= (k_q == NW'(1)) ? '0 : k_q - NW'(1);
			end
			S_LK_WR: begin
				if (k_q == '0) begin
					first_q <= ord_rdata;
				end
				prev_q <= ord_rdata;
				k_q    <= k_q + NW'(1);
			end
			S_LK_END: begin
				c_q   <= '0;
				pos_q <= '0;
			end
			S_CU_WR: begin
				cursors_q[c_q] <= ord_rdata;
				pos_q          <= pos_q + step_q;
				c_q            <= c_q + CW'(1);
			end
			default: ;
		endcase
	end
endmodule
